@@ rtl/core/tcw_pkg.sv @@
// tcw_pkg: shared constants, types and command encoding of the text console writer
// no dependencies; used by every file in rtl/core except tcw_if.sv
package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TERMINALS   = 7;
    localparam int CELLS       = ROWS * COLUMNS;
    localparam int FIFO_DEPTH  = 2;

    localparam int TERM_W = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
    localparam int CELL_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = TERM_W + CELL_W;
    localparam int POS_W  = $clog2(CELLS + 1);
    localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    localparam logic [3:0] DEFAULT_FG = 4'd7;
    localparam logic [3:0] DEFAULT_BG = 4'd0;
    localparam logic [7:0] NEWLINE    = 8'd10;

    typedef logic [TERM_W-1:0] t_term;
    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [POS_W-1:0]  t_pos;

    typedef enum logic [2:0] {
        OP_PUT   = 3'd0,
        OP_FG    = 3'd1,
        OP_BG    = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CMD_CHAR,
        CMD_NEWLINE,
        CMD_FG,
        CMD_BG,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] character;
        logic [3:0] color;
        t_cell      cell_idx;
        logic       in_range;
    } t_cmd;

endpackage

@@ rtl/core/tcw_if.sv @@
// tcw_in_if, tcw_out_if: valid/ready channels for input and result items
// no dependencies
interface tcw_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [7:0]  character;
    logic [3:0]  color;
    logic [10:0] cell_index;

    modport source (output valid, operation, character, color, cell_index, input ready);
    modport sink   (input valid, operation, character, color, cell_index, output ready);
endinterface

interface tcw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;

    modport source (output valid, cell_char, cell_color, cursor_row, cursor_col, input ready);
    modport sink   (input valid, cell_char, cell_color, cursor_row, cursor_col, output ready);
endinterface

@@ rtl/core/tcw_front.sv @@
// tcw_front: accepts input items and decodes them into commands for the queue
// depends on tcw_pkg and tcw_in_if
module tcw_front (
    tcw_in_if.sink        i_in,
    input  logic          i_full,
    input  logic          i_init_busy,
    output logic          o_push,
    output tcw_pkg::t_cmd o_cmd
);

    always_comb begin
        o_cmd.character = i_in.character;
        o_cmd.color     = i_in.color;
        o_cmd.cell_idx  = tcw_pkg::t_cell'(i_in.cell_index);
        o_cmd.in_range  = (int'(i_in.cell_index) < tcw_pkg::CELLS);
        unique case (tcw_pkg::t_op'(i_in.operation))
            tcw_pkg::OP_PUT: begin
                o_cmd.kind = (i_in.character == tcw_pkg::NEWLINE) ?
                             tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_CHAR;
            end
            tcw_pkg::OP_FG:    o_cmd.kind = tcw_pkg::CMD_FG;
            tcw_pkg::OP_BG:    o_cmd.kind = tcw_pkg::CMD_BG;
            tcw_pkg::OP_CLEAR: o_cmd.kind = tcw_pkg::CMD_CLEAR;
            tcw_pkg::OP_READ:  o_cmd.kind = tcw_pkg::CMD_READ;
            default:           o_cmd.kind = tcw_pkg::CMD_NOP;
        endcase
    end

    assign i_in.ready = !i_full && !i_init_busy;
    assign o_push     = i_in.valid && i_in.ready;

endmodule

@@ rtl/core/tcw_fifo.sv @@
// tcw_fifo: short command queue between the front and back parts
// depends on tcw_pkg
module tcw_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output tcw_pkg::t_cmd o_cmd
);

    tcw_pkg::t_cmd            r_mem [tcw_pkg::FIFO_DEPTH];
    logic [tcw_pkg::PTR_W-1:0] r_wp, r_rp;
    logic [tcw_pkg::PTR_W:0]   r_count;

    assign o_full  = (int'(r_count) == tcw_pkg::FIFO_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (int'(r_wp) == tcw_pkg::FIFO_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (int'(r_rp) == tcw_pkg::FIFO_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/tcw_back.sv @@
// tcw_back: executes commands on the cell memory and per-terminal cursor state
// depends on tcw_pkg and tcw_out_if
module tcw_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_data,
    input  logic          i_cmd_valid,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_init_busy,
    tcw_out_if.source     o_out
);

    typedef enum logic [2:0] {S_INIT, S_IDLE, S_EXEC, S_SCROLL, S_CLEAR, S_READ} t_state;

    t_state          r_state;
    tcw_pkg::t_cmd   r_cmd;
    tcw_pkg::t_term  r_term;
    tcw_pkg::t_addr  r_init;
    tcw_pkg::t_pos   r_pos;
    tcw_pkg::t_row   r_row [tcw_pkg::TERMINALS];
    tcw_pkg::t_col   r_col [tcw_pkg::TERMINALS];
    logic [3:0]      r_fg  [tcw_pkg::TERMINALS];
    logic [3:0]      r_bg  [tcw_pkg::TERMINALS];
    logic [15:0]     r_mem [2**tcw_pkg::ADDR_W];
    logic [15:0]     r_rdata;
    logic            r_out_valid;
    logic [7:0]      r_out_char, r_out_color;
    logic [4:0]      r_out_row;
    logic [6:0]      r_out_col;

    tcw_pkg::t_row   w_row, w_next_row;
    tcw_pkg::t_col   w_col, w_next_col;
    logic [3:0]      w_fg, w_bg;
    tcw_pkg::t_cell  w_put_cell;
    logic            w_we;
    tcw_pkg::t_addr  w_waddr, w_raddr;
    logic [15:0]     w_wdata;

    assign w_row = r_row[r_term];
    assign w_col = r_col[r_term];
    assign w_fg  = r_fg[r_term];
    assign w_bg  = r_bg[r_term];
    assign w_put_cell = tcw_pkg::t_cell'(int'(w_row) * tcw_pkg::COLUMNS + int'(w_col));

    assign o_pop       = (r_state == S_IDLE) && i_cmd_valid && !r_out_valid;
    assign o_init_busy = (r_state == S_INIT);

    // cursor after a put char or newline
    always_comb begin
        if (r_cmd.kind == tcw_pkg::CMD_NEWLINE ||
            int'(w_col) == tcw_pkg::COLUMNS - 1) begin
            w_next_row = w_row + 1'b1;
            w_next_col = '0;
        end else begin
            w_next_row = w_row;
            w_next_col = w_col + 1'b1;
        end
    end

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_term, tcw_pkg::t_cell'(r_pos)};
        w_wdata = '0;
        w_raddr = {r_term, r_cmd.cell_idx};
        unique case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_init;
            end
            S_EXEC: begin
                if (r_cmd.kind == tcw_pkg::CMD_CHAR && int'(w_row) < tcw_pkg::ROWS) begin
                    w_we    = 1'b1;
                    w_waddr = {r_term, w_put_cell};
                    w_wdata = {w_bg, w_fg, r_cmd.character};
                end
            end
            S_SCROLL: begin
                w_raddr = {r_term, tcw_pkg::t_cell'(int'(r_pos) + tcw_pkg::COLUMNS)};
                w_we    = (r_pos != '0);
                w_waddr = {r_term, tcw_pkg::t_cell'(r_pos - 1'b1)};
                w_wdata = (int'(r_pos) <= tcw_pkg::CELLS - tcw_pkg::COLUMNS) ? r_rdata : '0;
            end
            S_CLEAR: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_term      <= '0;
            r_init      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < tcw_pkg::TERMINALS; t++) begin
                r_row[t] <= '0;
                r_col[t] <= '0;
                r_fg[t]  <= tcw_pkg::DEFAULT_FG;
                r_bg[t]  <= tcw_pkg::DEFAULT_BG;
            end
        end else begin
            if (i_cfg_we && int'(i_cfg_data) < tcw_pkg::TERMINALS) begin
                r_term <= tcw_pkg::t_term'(i_cfg_data);
            end
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_init <= r_init + 1'b1;
                    if (&r_init) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_out_char  <= '0;
                    r_out_color <= '0;
                    r_out_row   <= 5'(w_row);
                    r_out_col   <= 7'(w_col);
                    unique case (r_cmd.kind)
                        tcw_pkg::CMD_CHAR, tcw_pkg::CMD_NEWLINE: begin
                            if (int'(w_row) >= tcw_pkg::ROWS) begin
                                r_pos   <= '0;
                                r_state <= S_SCROLL;
                            end else begin
                                r_row[r_term] <= w_next_row;
                                r_col[r_term] <= w_next_col;
                                r_out_row     <= 5'(w_next_row);
                                r_out_col     <= 7'(w_next_col);
                                r_out_valid   <= 1'b1;
                                r_state       <= S_IDLE;
                            end
                        end
                        tcw_pkg::CMD_FG: begin
                            r_fg[r_term] <= r_cmd.color;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                        tcw_pkg::CMD_BG: begin
                            r_bg[r_term] <= r_cmd.color;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                        tcw_pkg::CMD_CLEAR: begin
                            r_pos   <= '0;
                            r_state <= S_CLEAR;
                        end
                        tcw_pkg::CMD_READ: begin
                            if (r_cmd.in_range) begin
                                r_state <= S_READ;
                            end else begin
                                r_out_valid <= 1'b1;
                                r_state     <= S_IDLE;
                            end
                        end
                        default: begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    endcase
                end
                S_SCROLL: begin
                    // read one row ahead, write the cell read in the step before
                    r_pos <= r_pos + 1'b1;
                    if (int'(r_pos) == tcw_pkg::CELLS) begin
                        r_row[r_term] <= tcw_pkg::t_row'(tcw_pkg::ROWS - 1);
                        r_col[r_term] <= '0;
                        r_state       <= S_EXEC;
                    end
                end
                S_CLEAR: begin
                    r_pos <= r_pos + 1'b1;
                    if (int'(r_pos) == tcw_pkg::CELLS - 1) begin
                        r_row[r_term] <= '0;
                        r_col[r_term] <= '0;
                        r_out_row     <= '0;
                        r_out_col     <= '0;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_out_char  <= r_rdata[7:0];
                    r_out_color <= r_rdata[15:8];
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.cell_char  = r_out_char;
    assign o_out.cell_color = r_out_color;
    assign o_out.cursor_row = r_out_row;
    assign o_out.cursor_col = r_out_col;

`ifndef ASSERT_OFF
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(w_col) < tcw_pkg::COLUMNS)
        else $error("cursor column out of range");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(w_row) <= tcw_pkg::ROWS)
        else $error("cursor row out of range");
    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_out_valid)
        else $error("command taken while result pending");
    a_idle_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("memory write while idle");
    a_busy_noaccept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_pop)
        else $error("command taken during init sweep");
`endif

endmodule

@@ rtl/core/text_console_writer.sv @@
// text_console_writer: multi-terminal text console, put char, colors, clear, cell read
// after reset all 2**ADDR_W memory words (16384) are swept to zero, input not ready meanwhile
// a simple item is popped in S_IDLE and executed in S_EXEC, then its result is registered; a read also passes S_READ
// clear terminal zeroes all CELLS cells of the active terminal in S_CLEAR; a scroll adds an S_SCROLL sweep
// rate is set by the back part: one command in flight, next one taken after the result leaves
// reset is synchronous and active low; terminal 0 active, colors 7 on 0, cursors at home
module text_console_writer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_data,
    tcw_in_if.sink     i_in,
    tcw_out_if.source  o_out
);

    // front to queue
    logic          w_push;
    tcw_pkg::t_cmd w_push_cmd;
    logic          w_full;
    // queue to back
    logic          w_cmd_valid;
    tcw_pkg::t_cmd w_cmd;
    logic          w_pop;
    // back holds input off during the reset sweep
    logic          w_init_busy;

    // decode of each incoming item into a command
    tcw_front u_front (
        .i_in        (i_in),
        .i_full      (w_full),
        .i_init_busy (w_init_busy),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    // short queue lets the front keep taking items while the back is busy
    tcw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd)
    );

    // execution: cell memory, cursors, colors, scroll and clear sweeps, result register
    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_init_busy (w_init_busy),
        .o_out       (o_out)
    );

endmodule
